FILE: design/sct_pkg.sv
// ----------------------------------------------------------------------------
// sct_pkg
// Operation codes, field widths and the multiplier count shared by the
// collision tester and its query channel interface.
// ----------------------------------------------------------------------------
package sct_pkg;

  // Width of the operation code field.
  localparam int FUNC_W = 3;

  // Width of the segment radius field, and of its square.
  localparam int RAD_W = 16;
  localparam int R2_W  = 2 * RAD_W;

  // Number of multipliers in the product stage.
  localparam int MUL_CNT = 11;

  typedef enum logic [FUNC_W-1:0] {
    FN_PT_RECT     = 3'd0,
    FN_RECT_RECT   = 3'd1,
    FN_PT_CIRCLE   = 3'd2,
    FN_CIRC_CIRC   = 3'd3,
    FN_CIRC_RECT   = 3'd4,
    FN_SEG_CIRCLE  = 3'd5
  } func_t;

endpackage

FILE: design/sct_in_if.sv
// ----------------------------------------------------------------------------
// sct_in_if
// Query channel: valid/ready handshake carrying the operation code, two
// coordinate quadruples and the segment radius.
// ----------------------------------------------------------------------------
interface sct_in_if import sct_pkg::*; #(
  parameter int COORD_BITS = 16
) ();

  logic                         valid;
  logic                         ready;
  logic        [FUNC_W-1:0]     func;
  logic signed [COORD_BITS-1:0] a_left;
  logic signed [COORD_BITS-1:0] a_top;
  logic signed [COORD_BITS-1:0] a_right;
  logic signed [COORD_BITS-1:0] a_bottom;
  logic signed [COORD_BITS-1:0] b_left;
  logic signed [COORD_BITS-1:0] b_top;
  logic signed [COORD_BITS-1:0] b_right;
  logic signed [COORD_BITS-1:0] b_bottom;
  logic        [RAD_W-1:0]      seg_radius;

  modport source (
    output valid, func, a_left, a_top, a_right, a_bottom,
           b_left, b_top, b_right, b_bottom, seg_radius,
    input  ready
  );

  modport sink (
    input  valid, func, a_left, a_top, a_right, a_bottom,
           b_left, b_top, b_right, b_bottom, seg_radius,
    output ready
  );

endinterface

FILE: design/sct_out_if.sv
// ----------------------------------------------------------------------------
// sct_out_if
// Result channel: valid/ready handshake carrying the single hit bit.
// ----------------------------------------------------------------------------
interface sct_out_if ();

  logic valid;
  logic ready;
  logic hit;

  modport source (
    output valid, hit,
    input  ready
  );

  modport sink (
    input  valid, hit,
    output ready
  );

endinterface

FILE: design/shape_collision_tester.sv
// ----------------------------------------------------------------------------
// shape_collision_tester
// Pipeline: eight register stages, stage 1 to stage 8; out_ch.valid rises when the
// accepted transaction reaches the stage 8 output register.
// Throughput: one transaction per clock while the result channel is not
// stalled, set by the fully pipelined multiplier stages; every stage has its own valid bit and stall enable.
// Reset: synchronous, active low, clears the stage valid bits only.
// ----------------------------------------------------------------------------
module shape_collision_tester import sct_pkg::*; #(
  parameter int COORD_BITS = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  sct_in_if.sink        in_ch,
  sct_out_if.source     out_ch
);

  // Coordinate width, and the width that holds a sum or difference of two
  // coordinates.
  localparam int CW  = COORD_BITS;
  localparam int CW1 = CW + 1;
  // Multiplier operand width: a coordinate difference, or the unsigned
  // segment radius with a sign bit in front of it.
  localparam int OP_W = (CW1 > RAD_W + 1) ? CW1 : RAD_W + 1;
  localparam int PR_W = 2 * OP_W;
  // The wide segment compare splits its operands into OP_W-bit halves.
  localparam int U_W    = PR_W;
  localparam int WIDE_W = 4 * OP_W;
  localparam int NSTG   = 8;

  // Halving with truncation toward zero, as integer division by two does.
  function automatic logic signed [CW1-1:0] half_tz(input logic signed [CW1-1:0] s);
    logic signed [CW1-1:0] t;
    t = s + $signed({{(CW1-1){1'b0}}, s[CW1-1]});
    return t >>> 1;
  endfunction

  function automatic logic signed [CW1-1:0] sx1(input logic signed [CW-1:0] v);
    return CW1'(v);
  endfunction

  function automatic logic signed [OP_W-1:0] sxo(input logic signed [CW1-1:0] v);
    return OP_W'(v);
  endfunction

  // Strict containment of a point in a box; an inverted box holds nothing.
  function automatic logic pt_in_rect(
    input logic signed [CW1-1:0] x, input logic signed [CW1-1:0] y,
    input logic signed [CW1-1:0] l, input logic signed [CW1-1:0] t,
    input logic signed [CW1-1:0] r, input logic signed [CW1-1:0] b
  );
    return (l < x) && (x < r) && (t < y) && (y < b);
  endfunction

  // --------------------------------------------------------------------------
  // Stall control. A stage takes new contents when it is empty or when the
  // stage after it moves on, so bubbles are squeezed out and a stalled
  // result never blocks the empty stages behind it.
  // --------------------------------------------------------------------------
  logic [NSTG:1] vld_r;
  logic [NSTG:1] stg_en;

  always_comb begin
    stg_en[NSTG] = !vld_r[NSTG] || out_ch.ready;
    for (int k = NSTG - 1; k >= 1; k--) begin
      stg_en[k] = !vld_r[k] || stg_en[k+1];
    end
  end

  assign in_ch.ready = stg_en[1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (stg_en[1]) begin
        vld_r[1] <= in_ch.valid;
      end
      for (int k = 2; k <= NSTG; k++) begin
        if (stg_en[k]) begin
          vld_r[k] <= vld_r[k-1];
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: register the accepted transaction.
  // --------------------------------------------------------------------------
  logic        [FUNC_W-1:0] func_r1;
  logic signed [CW-1:0]     al_r1, at_r1, ar_r1, ab_r1;
  logic signed [CW-1:0]     bl_r1, bt_r1, br_r1, bb_r1;
  logic        [RAD_W-1:0]  rad_r1;

  always_ff @(posedge clk) begin
    if (stg_en[1]) begin
      func_r1 <= in_ch.func;
      al_r1   <= in_ch.a_left;
      at_r1   <= in_ch.a_top;
      ar_r1   <= in_ch.a_right;
      ab_r1   <= in_ch.a_bottom;
      bl_r1   <= in_ch.b_left;
      bt_r1   <= in_ch.b_top;
      br_r1   <= in_ch.b_right;
      bb_r1   <= in_ch.b_bottom;
      rad_r1  <= in_ch.seg_radius;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: circle centres and radii of both boxes, and the segment
  // direction and offsets to the circle centre from either end point.
  // --------------------------------------------------------------------------
  logic signed [CW1-1:0] cxa_nxt, cya_nxt, ra_nxt, cxb_nxt, cyb_nxt, rb_nxt;
  logic signed [CW1-1:0] vx_nxt, vy_nxt, sdx_nxt, sdy_nxt, ex_nxt, ey_nxt;

  always_comb begin
    cxa_nxt = half_tz(sx1(ar_r1) + sx1(al_r1));
    cya_nxt = half_tz(sx1(ab_r1) + sx1(at_r1));
    ra_nxt  = half_tz(sx1(ar_r1) - sx1(al_r1));
    cxb_nxt = half_tz(sx1(br_r1) + sx1(bl_r1));
    cyb_nxt = half_tz(sx1(bb_r1) + sx1(bt_r1));
    rb_nxt  = half_tz(sx1(br_r1) - sx1(bl_r1));
    vx_nxt  = sx1(ar_r1) - sx1(al_r1);
    vy_nxt  = sx1(ab_r1) - sx1(at_r1);
    sdx_nxt = sx1(bl_r1) - sx1(al_r1);
    sdy_nxt = sx1(bt_r1) - sx1(at_r1);
    ex_nxt  = sx1(bl_r1) - sx1(ar_r1);
    ey_nxt  = sx1(bt_r1) - sx1(ab_r1);
  end

  logic        [FUNC_W-1:0] func_r2;
  logic signed [CW-1:0]     al_r2, at_r2, ar_r2, ab_r2;
  logic signed [CW-1:0]     bl_r2, bt_r2, br_r2, bb_r2;
  logic        [RAD_W-1:0]  rad_r2;
  logic signed [CW1-1:0]    cxa_r, cya_r, ra_r, cxb_r, cyb_r, rb_r;
  logic signed [CW1-1:0]    vx_r, vy_r, sdx_r, sdy_r, ex_r, ey_r;

  always_ff @(posedge clk) begin
    if (stg_en[2]) begin
      func_r2 <= func_r1;
      al_r2   <= al_r1;
      at_r2   <= at_r1;
      ar_r2   <= ar_r1;
      ab_r2   <= ab_r1;
      bl_r2   <= bl_r1;
      bt_r2   <= bt_r1;
      br_r2   <= br_r1;
      bb_r2   <= bb_r1;
      rad_r2  <= rad_r1;
      cxa_r   <= cxa_nxt;
      cya_r   <= cya_nxt;
      ra_r    <= ra_nxt;
      cxb_r   <= cxb_nxt;
      cyb_r   <= cyb_nxt;
      rb_r    <= rb_nxt;
      vx_r    <= vx_nxt;
      vy_r    <= vy_nxt;
      sdx_r   <= sdx_nxt;
      sdy_r   <= sdy_nxt;
      ex_r    <= ex_nxt;
      ey_r    <= ey_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3: all box containment tests, which need no multiplier, and the
  // operand selection for the shared multiplier bank.
  //
  // Multiplier slots by operation:
  //   point or circle pair : 0 dx^2, 1 dy^2, 2 radius^2
  //   circle against box   : 0 left dx^2, 1 right dx^2, 2 radius^2,
  //                          3 top dy^2, 4 bottom dy^2
  //   segment              : 0 dx^2, 1 dy^2, 2 radius^2, 3 vx^2, 4 vy^2,
  //                          5 vx*dx, 6 vy*dy, 7 ex^2, 8 ey^2,
  //                          9 vx*dy, 10 vy*dx
  // Slot 2 carries the radius in every circle and segment operation, so its
  // sign decides whether the circle contains any point at all.
  // --------------------------------------------------------------------------
  logic signed [OP_W-1:0] opa_nxt [MUL_CNT];
  logic signed [OP_W-1:0] opb_nxt [MUL_CNT];
  logic                   rect_hit_nxt;
  logic                   rad_pos_nxt;

  always_comb begin
    logic signed [CW1-1:0] al1, at1, ar1, ab1, bl1, bt1, br1, bb1;
    logic signed [OP_W-1:0] seg_rad;
    logic pr_in;
    logic pr_ovl;
    logic pr_crn;
    al1 = sx1(al_r2);
    at1 = sx1(at_r2);
    ar1 = sx1(ar_r2);
    ab1 = sx1(ab_r2);
    bl1 = sx1(bl_r2);
    bt1 = sx1(bt_r2);
    br1 = sx1(br_r2);
    bb1 = sx1(bb_r2);
    seg_rad = $signed({{(OP_W-RAD_W){1'b0}}, rad_r2});

    pr_in  = pt_in_rect(al1, at1, bl1, bt1, br1, bb1);
    pr_ovl = (al1 < br1) && (bl1 < ar1) && (at1 < bb1) && (bt1 < ab1);
    // Extreme points of circle a: top, bottom, left and right of its box,
    // on the centre lines.
    pr_crn = pt_in_rect(cxa_r, at1, bl1, bt1, br1, bb1)
          || pt_in_rect(cxa_r, ab1, bl1, bt1, br1, bb1)
          || pt_in_rect(al1, cya_r, bl1, bt1, br1, bb1)
          || pt_in_rect(ar1, cya_r, bl1, bt1, br1, bb1);

    for (int i = 0; i < MUL_CNT; i++) begin
      opa_nxt[i] = '0;
      opb_nxt[i] = '0;
    end
    rect_hit_nxt = 1'b0;

    case (func_r2)
      FN_PT_RECT: begin
        rect_hit_nxt = pr_in;
      end
      FN_RECT_RECT: begin
        rect_hit_nxt = pr_ovl;
      end
      FN_PT_CIRCLE: begin
        opa_nxt[0] = sxo(al1) - sxo(cxb_r);
        opa_nxt[1] = sxo(at1) - sxo(cyb_r);
        opa_nxt[2] = sxo(rb_r);
      end
      FN_CIRC_CIRC: begin
        opa_nxt[0] = sxo(cxb_r) - sxo(cxa_r);
        opa_nxt[1] = sxo(cyb_r) - sxo(cya_r);
        opa_nxt[2] = sxo(ra_r) + sxo(rb_r);
      end
      FN_CIRC_RECT: begin
        rect_hit_nxt = pr_crn;
        opa_nxt[0] = sxo(bl1) - sxo(cxa_r);
        opa_nxt[1] = sxo(br1) - sxo(cxa_r);
        opa_nxt[2] = sxo(ra_r);
        opa_nxt[3] = sxo(bt1) - sxo(cya_r);
        opa_nxt[4] = sxo(bb1) - sxo(cya_r);
      end
      FN_SEG_CIRCLE: begin
        opa_nxt[0]  = sxo(sdx_r);
        opa_nxt[1]  = sxo(sdy_r);
        opa_nxt[2]  = seg_rad;
        opa_nxt[3]  = sxo(vx_r);
        opa_nxt[4]  = sxo(vy_r);
        opa_nxt[5]  = sxo(vx_r);
        opb_nxt[5]  = sxo(sdx_r);
        opa_nxt[6]  = sxo(vy_r);
        opb_nxt[6]  = sxo(sdy_r);
        opa_nxt[7]  = sxo(ex_r);
        opa_nxt[8]  = sxo(ey_r);
        opa_nxt[9]  = sxo(vx_r);
        opb_nxt[9]  = sxo(sdy_r);
        opa_nxt[10] = sxo(vy_r);
        opb_nxt[10] = sxo(sdx_r);
      end
      default: begin
        rect_hit_nxt = 1'b0;
      end
    endcase

    // Slots 0 to 4, 7 and 8 are squares.
    if (func_r2 != FN_SEG_CIRCLE) begin
      for (int i = 0; i < 5; i++) begin
        opb_nxt[i] = opa_nxt[i];
      end
    end else begin
      for (int i = 0; i < 5; i++) begin
        opb_nxt[i] = opa_nxt[i];
      end
      opb_nxt[7] = opa_nxt[7];
      opb_nxt[8] = opa_nxt[8];
    end

    rad_pos_nxt = (opa_nxt[2] > 0);
  end

  logic        [FUNC_W-1:0] func_r3;
  logic signed [OP_W-1:0]   opa_r [MUL_CNT];
  logic signed [OP_W-1:0]   opb_r [MUL_CNT];
  logic                     rect_hit_r3;
  logic                     rad_pos_r3;

  always_ff @(posedge clk) begin
    if (stg_en[3]) begin
      func_r3     <= func_r2;
      opa_r       <= opa_nxt;
      opb_r       <= opb_nxt;
      rect_hit_r3 <= rect_hit_nxt;
      rad_pos_r3  <= rad_pos_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 4: the multiplier bank, one signed OP_W by OP_W product per slot.
  // --------------------------------------------------------------------------
  logic signed [PR_W-1:0] prod_nxt [MUL_CNT];

  always_comb begin
    for (int i = 0; i < MUL_CNT; i++) begin
      prod_nxt[i] = opa_r[i] * opb_r[i];
    end
  end

  logic        [FUNC_W-1:0] func_r4;
  logic signed [PR_W-1:0]   prod_r [MUL_CNT];
  logic                     rect_hit_r4;
  logic                     rad_pos_r4;

  always_ff @(posedge clk) begin
    if (stg_en[4]) begin
      func_r4     <= func_r3;
      prod_r      <= prod_nxt;
      rect_hit_r4 <= rect_hit_r3;
      rad_pos_r4  <= rad_pos_r3;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 5: squared distance compares. Every test except the middle part
  // of a segment is settled here; for that case the absolute cross product
  // and the squared segment length go on to the wide compare.
  // --------------------------------------------------------------------------
  logic              early_hit_nxt;
  logic              need_wide_nxt;
  logic [U_W-1:0]    acr_nxt;
  logic [U_W-1:0]    len2_nxt;
  logic [R2_W-1:0]   r2_nxt;

  always_comb begin
    logic signed [PR_W:0] d2, len2, dot, e2, cr, acr_s;
    logic near_hit;
    logic crn_hit;
    logic circ_hit;
    logic seg_ok;
    logic seg_easy;
    logic seg_mid;
    d2   = (PR_W+1)'(prod_r[0]) + (PR_W+1)'(prod_r[1]);
    len2 = (PR_W+1)'(prod_r[3]) + (PR_W+1)'(prod_r[4]);
    dot  = (PR_W+1)'(prod_r[5]) + (PR_W+1)'(prod_r[6]);
    e2   = (PR_W+1)'(prod_r[7]) + (PR_W+1)'(prod_r[8]);
    cr   = (PR_W+1)'(prod_r[9]) - (PR_W+1)'(prod_r[10]);
    acr_s = cr[PR_W] ? -cr : cr;

    near_hit = (d2 < (PR_W+1)'(prod_r[2]));
    // Corners of box b against circle a.
    crn_hit = ((PR_W+1)'(prod_r[0]) + (PR_W+1)'(prod_r[3]) < (PR_W+1)'(prod_r[2]))
           || ((PR_W+1)'(prod_r[1]) + (PR_W+1)'(prod_r[3]) < (PR_W+1)'(prod_r[2]))
           || ((PR_W+1)'(prod_r[0]) + (PR_W+1)'(prod_r[4]) < (PR_W+1)'(prod_r[2]))
           || ((PR_W+1)'(prod_r[1]) + (PR_W+1)'(prod_r[4]) < (PR_W+1)'(prod_r[2]));
    circ_hit = rad_pos_r4 && near_hit;

    // A zero-length segment or a zero radius never hits. Before the start
    // the nearest point is the start, past the end it is the end.
    seg_ok  = rad_pos_r4 && (len2 != 0);
    seg_mid = (dot > 0) && (dot < len2);
    if (dot <= 0) begin
      seg_easy = near_hit;
    end else if (dot >= len2) begin
      seg_easy = (e2 < (PR_W+1)'(prod_r[2]));
    end else begin
      seg_easy = 1'b0;
    end

    early_hit_nxt = 1'b0;
    need_wide_nxt = 1'b0;
    case (func_r4)
      FN_PT_RECT:    early_hit_nxt = rect_hit_r4;
      FN_RECT_RECT:  early_hit_nxt = rect_hit_r4;
      FN_PT_CIRCLE:  early_hit_nxt = circ_hit;
      FN_CIRC_CIRC:  early_hit_nxt = circ_hit;
      FN_CIRC_RECT:  early_hit_nxt = rect_hit_r4 || (rad_pos_r4 && crn_hit);
      FN_SEG_CIRCLE: begin
        early_hit_nxt = seg_ok && seg_easy;
        need_wide_nxt = seg_ok && seg_mid;
      end
      default:       early_hit_nxt = 1'b0;
    endcase

    acr_nxt  = acr_s[U_W-1:0];
    len2_nxt = len2[U_W-1:0];
    r2_nxt   = prod_r[2][R2_W-1:0];
  end

  logic            early_hit_r5, need_wide_r5;
  logic [U_W-1:0]  acr_r, len2_r;
  logic [R2_W-1:0] r2_r;

  always_ff @(posedge clk) begin
    if (stg_en[5]) begin
      early_hit_r5 <= early_hit_nxt;
      need_wide_r5 <= need_wide_nxt;
      acr_r        <= acr_nxt;
      len2_r       <= len2_nxt;
      r2_r         <= r2_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 6: partial products for cross^2 against radius^2 * length^2.
  // Both wide operands are cut into OP_W-bit halves.
  // --------------------------------------------------------------------------
  logic [PR_W-1:0]      pp_hh_nxt, pp_hl_nxt, pp_ll_nxt;
  logic [R2_W+OP_W-1:0] pq_h_nxt, pq_l_nxt;

  always_comb begin
    logic [OP_W-1:0] acr_h, acr_l, len_h, len_l;
    acr_h = acr_r[U_W-1:OP_W];
    acr_l = acr_r[OP_W-1:0];
    len_h = len2_r[U_W-1:OP_W];
    len_l = len2_r[OP_W-1:0];
    pp_hh_nxt = PR_W'(acr_h) * PR_W'(acr_h);
    pp_hl_nxt = PR_W'(acr_h) * PR_W'(acr_l);
    pp_ll_nxt = PR_W'(acr_l) * PR_W'(acr_l);
    pq_h_nxt  = (R2_W+OP_W)'(r2_r) * (R2_W+OP_W)'(len_h);
    pq_l_nxt  = (R2_W+OP_W)'(r2_r) * (R2_W+OP_W)'(len_l);
  end

  logic                 early_hit_r6, need_wide_r6;
  logic [PR_W-1:0]      pp_hh_r, pp_hl_r, pp_ll_r;
  logic [R2_W+OP_W-1:0] pq_h_r, pq_l_r;

  always_ff @(posedge clk) begin
    if (stg_en[6]) begin
      early_hit_r6 <= early_hit_r5;
      need_wide_r6 <= need_wide_r5;
      pp_hh_r      <= pp_hh_nxt;
      pp_hl_r      <= pp_hl_nxt;
      pp_ll_r      <= pp_ll_nxt;
      pq_h_r       <= pq_h_nxt;
      pq_l_r       <= pq_l_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 7: assemble both sides of the wide compare.
  // --------------------------------------------------------------------------
  logic [WIDE_W-1:0] lhs_nxt, rhs_nxt;

  always_comb begin
    lhs_nxt = {pp_hh_r, pp_ll_r} + (WIDE_W'(pp_hl_r) << (OP_W + 1));
    rhs_nxt = (WIDE_W'(pq_h_r) << OP_W) + WIDE_W'(pq_l_r);
  end

  logic              early_hit_r7, need_wide_r7;
  logic [WIDE_W-1:0] lhs_r, rhs_r;

  always_ff @(posedge clk) begin
    if (stg_en[7]) begin
      early_hit_r7 <= early_hit_r6;
      need_wide_r7 <= need_wide_r6;
      lhs_r        <= lhs_nxt;
      rhs_r        <= rhs_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 8: the output register. The centre lies within the radius of the
  // segment's interior when cross^2 < radius^2 * length^2.
  // --------------------------------------------------------------------------
  logic hit_nxt;
  logic hit_r;

  assign hit_nxt = early_hit_r7 || (need_wide_r7 && (lhs_r < rhs_r));

  always_ff @(posedge clk) begin
    if (stg_en[8]) begin
      hit_r <= hit_nxt;
    end
  end

  assign out_ch.valid = vld_r[NSTG];
  assign out_ch.hit   = hit_r;

endmodule
